@@ src/qtce_pkg.sv @@
// ----------------------------------------------------------------------------
// Quota table charge engine package
// Shared constants, operation and status codes, and the transfer and
// storage types of the quota table charge engine.
// ----------------------------------------------------------------------------
`default_nettype none

package qtce_pkg;

    // Table geometry.
    localparam int ENTRIES    = 64;
    localparam int NAME_BYTES = 32;
    localparam int NAME_W     = 256;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W      = $clog2(ENTRIES + 1);

    // Operation carried by a request.
    typedef enum logic [1:0] {
        MODE_SET    = 2'd0,
        MODE_CHARGE = 2'd1,
        MODE_RETURN = 2'd2,
        MODE_QUERY  = 2'd3
    } mode_t;

    // Completion status of a request.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EXCEEDED  = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_EXEC = 2'd2
    } state_t;

    // Request transfer.
    typedef struct packed {
        mode_t       mode;
        logic [7:0]  volume;
        logic [63:0] name_word0;
        logic [63:0] name_word1;
        logic [63:0] name_word2;
        logic [63:0] name_word3;
        logic [63:0] byte_count;
        logic [63:0] warning_limit;
        logic [63:0] hard_limit;
    } req_t;

    // Response transfer.
    typedef struct packed {
        status_t     status;
        logic        hit;
        logic [63:0] out_used;
        logic [63:0] out_warning;
        logic [63:0] out_hard_limit;
    } rsp_t;

    // One row of the key memory.
    typedef struct packed {
        logic [7:0]        volume;
        logic [NAME_W-1:0] name;
    } key_t;

    // One row of the account memory.
    typedef struct packed {
        logic [63:0] used;
        logic [63:0] warning;
        logic [63:0] hard;
    } acct_t;

endpackage

`default_nettype wire

@@ src/quota_table_charge_engine.sv @@
// ----------------------------------------------------------------------------
// Quota table charge engine
// Keyed quota table held in a key memory and an account memory. Each
// request scans the valid entries for its key, then sets limits, charges,
// returns or queries usage of the match; a set that misses adds an entry.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  --------  ---------  -------------------  --------------------------------
//  request   in         req_valid/req_stall  req (mode, key, counts, limits)
//  response  out        rsp_valid/rsp_stall  rsp (status, hit, usage, limits)
//
//  A request scans at most the fill count of entries (64 at most), and the
//  scan reads one key memory row per cycle; a new request is taken only
//  after the last one has left its execute state.
//  Valid entries always form a prefix of the table, so a fill count stands
//  in for per-entry valid bits and no clearing pass is needed after reset.
//  A held response does not block the next request transfer; it only holds
//  the final cycle of the following request.
//
`default_nettype none

module quota_table_charge_engine
    import qtce_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    // Keep name bytes up to the first zero byte and below NAME_BYTES.
    function automatic logic [NAME_W-1:0] canon_name(input logic [NAME_W-1:0] raw);
        logic [31:0]       zf;
        logic [31:0]       mask;
        logic [NAME_W-1:0] key;
        for (int k = 0; k < 32; k++) begin
            zf[k] = (raw[8*k +: 8] == 8'd0) || (k >= NAME_BYTES);
        end
        key = '0;
        for (int k = 0; k < 32; k++) begin
            mask = (32'd2 << k) - 32'd1;
            if ((zf & mask) == 32'd0)
            begin
                key[8*k +: 8] = raw[8*k +: 8];
            end
        end
        return key;
    endfunction

    // Memories.
    key_t  key_mem  [ENTRIES];
    acct_t acct_mem [ENTRIES];

    key_t  key_q;
    acct_t acct_q;

    // Control registers.
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic             rsp_valid_reg, rsp_valid_next;

    // Request and response payload registers.
    mode_t             mode_reg;
    logic [7:0]        vol_reg;
    logic [NAME_W-1:0] name_reg;
    logic [63:0]       bytes_reg;
    logic [63:0]       warn_reg;
    logic [63:0]       hard_reg;
    rsp_t              rsp_reg;

    // Control and datapath signals.
    logic             accept;
    logic             issue;
    logic             match;
    logic             rsp_free;
    logic             exec_go;
    logic             table_free;
    logic [IDX_W-1:0] key_rd_addr;
    logic [IDX_W-1:0] acct_rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic             acct_we;
    logic             key_we;
    acct_t            acct_new;
    rsp_t             rsp_calc;
    logic [64:0]      sum;
    logic             exceed;

    assign accept     = req_valid && !req_stall;
    assign match      = cmp_vld_reg && (key_q == {vol_reg, name_reg});
    assign table_free = (fill_reg < CNT_W'(ENTRIES));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (match || !issue)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb
    begin
        req_stall    = 1'b1;
        issue        = 1'b0;
        exec_go      = 1'b0;
        rsp_free     = !rsp_valid_reg || !rsp_stall;
        key_rd_addr  = scan_reg[IDX_W-1:0];
        acct_rd_addr = hit_idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
            end
            S_SCAN:
            begin
                issue        = (scan_reg < fill_reg);
                acct_rd_addr = cmp_idx_reg;
            end
            S_EXEC:
            begin
                exec_go = rsp_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    // Scan bookkeeping.
    always_comb
    begin
        scan_next    = scan_reg;
        cmp_vld_next = cmp_vld_reg;
        cmp_idx_next = cmp_idx_reg;
        hit_next     = hit_reg;
        hit_idx_next = hit_idx_reg;
        if (accept)
        begin
            scan_next    = '0;
            cmp_vld_next = 1'b0;
            hit_next     = 1'b0;
        end
        else if (state_reg == S_SCAN)
        begin
            scan_next    = issue ? scan_reg + CNT_W'(1) : scan_reg;
            cmp_vld_next = issue;
            cmp_idx_next = scan_reg[IDX_W-1:0];
            if (match)
            begin
                hit_next     = 1'b1;
                hit_idx_next = cmp_idx_reg;
                cmp_vld_next = 1'b0;
            end
        end
    end

    // Charge arithmetic on the full 65-bit sum.
    assign sum    = {1'b0, acct_q.used} + {1'b0, bytes_reg};
    assign exceed = (acct_q.hard != 64'd0) && (sum > {1'b0, acct_q.hard});

    // Operation on the fetched entry, or a free entry claimed on a set miss.
    always_comb
    begin
        acct_new = acct_q;
        rsp_calc = '0;
        acct_we  = 1'b0;
        key_we   = 1'b0;
        wr_addr  = hit_idx_reg;
        rsp_calc.status = ST_OK;
        if (hit_reg)
        begin
            acct_we = 1'b1;
            case (mode_reg)
                MODE_SET:
                begin
                    acct_new.warning = warn_reg;
                    acct_new.hard    = hard_reg;
                end
                MODE_CHARGE:
                begin
                    if (exceed)
                    begin
                        rsp_calc.status = ST_EXCEEDED;
                    end
                    else
                    begin
                        acct_new.used = sum[64] ? '1 : sum[63:0];
                    end
                end
                MODE_RETURN:
                begin
                    acct_new.used = (bytes_reg > acct_q.used) ? 64'd0
                                                              : acct_q.used - bytes_reg;
                end
                default:
                begin
                    acct_new = acct_q;
                end
            endcase
            rsp_calc.hit            = 1'b1;
            rsp_calc.out_used       = acct_new.used;
            rsp_calc.out_warning    = acct_new.warning;
            rsp_calc.out_hard_limit = acct_new.hard;
        end
        else
        begin
            wr_addr = fill_reg[IDX_W-1:0];
            case (mode_reg)
                MODE_SET:
                begin
                    if (table_free)
                    begin
                        acct_we                 = 1'b1;
                        key_we                  = 1'b1;
                        acct_new.used           = 64'd0;
                        acct_new.warning        = warn_reg;
                        acct_new.hard           = hard_reg;
                        rsp_calc.hit            = 1'b1;
                        rsp_calc.out_used       = 64'd0;
                        rsp_calc.out_warning    = warn_reg;
                        rsp_calc.out_hard_limit = hard_reg;
                    end
                    else
                    begin
                        rsp_calc.status = ST_FULL;
                    end
                end
                MODE_CHARGE:
                begin
                    rsp_calc.status = ST_OK;
                end
                default:
                begin
                    rsp_calc.status = ST_NOT_FOUND;
                end
            endcase
        end
    end

    // Fill count and response valid.
    always_comb
    begin
        fill_next      = fill_reg;
        rsp_valid_next = rsp_valid_reg;
        if (exec_go && key_we)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        if (exec_go)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            scan_reg      <= '0;
            cmp_vld_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            scan_reg      <= scan_next;
            cmp_vld_reg   <= cmp_vld_next;
            hit_reg       <= hit_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Index registers.
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        hit_idx_reg <= hit_idx_next;
    end

    // Request capture with the canonical name key.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg  <= req.mode;
            vol_reg   <= req.volume;
            name_reg  <= canon_name({req.name_word3, req.name_word2,
                                     req.name_word1, req.name_word0});
            bytes_reg <= req.byte_count;
            warn_reg  <= req.warning_limit;
            hard_reg  <= req.hard_limit;
        end
    end

    // Response register.
    always_ff @(posedge clk)
    begin
        if (exec_go)
        begin
            rsp_reg <= rsp_calc;
        end
    end

    // Key memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (exec_go && key_we)
        begin
            key_mem[wr_addr] <= {vol_reg, name_reg};
        end
        key_q <= key_mem[key_rd_addr];
    end

    // Account memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (exec_go && acct_we)
        begin
            acct_mem[wr_addr] <= acct_new;
        end
        acct_q <= acct_mem[acct_rd_addr];
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The fill count never passes the table size.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(ENTRIES))
        else $error("fill count beyond table size");

    // A compared row always lies inside the filled prefix.
    a_cmp_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && cmp_vld_reg) |-> (CNT_W'(cmp_idx_reg) < fill_reg))
        else $error("compared row outside filled entries");

    // A new response is loaded only at the end of an execute cycle.
    a_rsp_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("response raised outside execute state");

    // A matched entry always lies inside the filled prefix.
    a_hit_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && hit_reg) |-> (CNT_W'(hit_idx_reg) < fill_reg))
        else $error("matched entry outside filled entries");

endmodule

`default_nettype wire
